/* rtl/tileable_fbm_value_noise_defines.svh */
// Assertion macros for the tileable fBm value noise RTL.
// Included by every file that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef TILEABLE_FBM_VALUE_NOISE_DEFINES_SVH
`define TILEABLE_FBM_VALUE_NOISE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TFVN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfvn assertion failed");
// next-cycle implication
`define TFVN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfvn assertion failed");
`else
`define TFVN_ASSERT_IMP(lbl, ante, cons)
`define TFVN_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/tfvn_pkg.sv */
// Shared constants and pipeline item types for the tileable fBm value noise block.
// No dependencies.
package tfvn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int COORD_BITS  = 28;
  localparam int INT_BITS    = 12;
  localparam int HASH_BITS   = 24;
  localparam int OUT_BITS    = 16;
  localparam int PER_BITS    = 18;
  localparam int BASE_BITS   = 11;
  localparam int OCT_BITS    = 4;
  localparam int OIDX_BITS   = 3;
  localparam int ACC_BITS    = 32;
  localparam int WEIGHT_BITS = 17;
  localparam int DIV_BITS    = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam logic [CFG_IDX_BITS-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_PERIOD  = 2'd1;

  // sample as it travels the wrap and octave cells
  typedef struct packed {
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [INT_BITS-1:0]  ix;
    logic [INT_BITS-1:0]  iy;
    logic [PER_BITS-1:0]  rx;
    logic [PER_BITS-1:0]  ry;
    logic [PER_BITS-1:0]  per;
    logic [OCT_BITS-1:0]  oct;
    logic [ACC_BITS-1:0]  acc;
  } item_t;

  // long-division state of the normalizer
  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [OUT_BITS-1:0] bits;
    logic [OUT_BITS-1:0] quo;
    logic [DIV_BITS-1:0] div;
  } quot_t;

endpackage

/* rtl/tfvn_wrap_cell.sv */
// One bit step of the lattice wrap: integer coordinate modulo base period.
// Depends on tfvn_pkg.
module tfvn_wrap_cell import tfvn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic [INT_BITS-1:0] part_x, part_y, dv;
  logic [INT_BITS-1:0] rem_x, rem_y;

  always_comb begin
    dv     = {1'b0, in_item.per[BASE_BITS-1:0]};
    part_x = {in_item.rx[BASE_BITS-1:0], in_item.ix[INT_BITS-1]};
    part_y = {in_item.ry[BASE_BITS-1:0], in_item.iy[INT_BITS-1]};
    rem_x  = (part_x >= dv) ? part_x - dv : part_x;
    rem_y  = (part_y >= dv) ? part_y - dv : part_y;
    item_nxt    = in_item;
    item_nxt.rx = PER_BITS'(rem_x);
    item_nxt.ry = PER_BITS'(rem_y);
    item_nxt.ix = {in_item.ix[INT_BITS-2:0], 1'b0};
    item_nxt.iy = {in_item.iy[INT_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/tfvn_octave_cell.sv */
// One octave of value noise: hash four wrapped corners, smoothstep blend, accumulate.
// Depends on tfvn_pkg and the assertion macro header.
`include "tileable_fbm_value_noise_defines.svh"
module tfvn_octave_cell import tfvn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [OIDX_BITS-1:0] octave_idx,
  input  logic                 in_valid,
  input  item_t                in_item,
  output logic                 out_valid,
  output item_t                out_item
);

  localparam logic [PER_BITS-1:0]    K_THREE    = PER_BITS'(3) << FRAC_BITS;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

  function automatic logic [HASH_BITS-1:0] blend(input logic [HASH_BITS-1:0] a,
                                                 input logic [HASH_BITS-1:0] b,
                                                 input logic [WEIGHT_BITS-1:0] w);
    logic [41:0] sum;
    sum = 42'(a) * 42'(WEIGHT_ONE - w) + 42'(b) * 42'(w);
    return sum[FRAC_BITS+HASH_BITS-1:FRAC_BITS];
  endfunction

  // stage 1: corner products, f*f, 3-2f
  logic [PER_BITS-1:0] x1, y1;
  logic [31:0] f2x_full, f2y_full;
  logic [3:0][31:0] m_nxt;
  logic s1_valid_r;
  item_t s1_item_r;
  logic [3:0][31:0] s1_m_r;  // x0*C1, x1*C1, y0*C2, y1*C2
  logic [FRAC_BITS-1:0] s1_f2x_r, s1_f2y_r;
  logic [PER_BITS-1:0] s1_kx_r, s1_ky_r;

  always_comb begin
    x1 = PER_BITS'(in_item.rx + 1'b1);
    y1 = PER_BITS'(in_item.ry + 1'b1);
    if (x1 == in_item.per) x1 = '0;
    if (y1 == in_item.per) y1 = '0;
    m_nxt[0] = 32'(in_item.rx) * HASH_MUL_X;
    m_nxt[1] = 32'(x1) * HASH_MUL_X;
    m_nxt[2] = 32'(in_item.ry) * HASH_MUL_Y;
    m_nxt[3] = 32'(y1) * HASH_MUL_Y;
    f2x_full = 32'(in_item.fx) * 32'(in_item.fx);
    f2y_full = 32'(in_item.fy) * 32'(in_item.fy);
  end

  // stage 2: corner sums, first mix, weights
  logic [3:0][31:0] n_sum, t_nxt;
  logic [33:0] ux_full, vy_full;
  logic s2_valid_r;
  item_t s2_item_r;
  logic [3:0][31:0] s2_t_r;
  logic [WEIGHT_BITS-1:0] s2_u_r, s2_v_r;

  always_comb begin
    n_sum[0] = s1_m_r[0] + s1_m_r[2];
    n_sum[1] = s1_m_r[1] + s1_m_r[2];
    n_sum[2] = s1_m_r[0] + s1_m_r[3];
    n_sum[3] = s1_m_r[1] + s1_m_r[3];
    for (int k = 0; k < 4; k++) begin
      t_nxt[k] = n_sum[k] ^ (n_sum[k] >> 13);
    end
    ux_full = 34'(s1_f2x_r) * 34'(s1_kx_r);
    vy_full = 34'(s1_f2y_r) * 34'(s1_ky_r);
  end

  // stage 3: mixing multiply
  logic s3_valid_r;
  item_t s3_item_r;
  logic [3:0][31:0] s3_p_r;
  logic [WEIGHT_BITS-1:0] s3_u_r, s3_v_r;

  // stage 4: final xor fold, horizontal blends
  logic [3:0][HASH_BITS-1:0] h;
  logic s4_valid_r;
  item_t s4_item_r;
  logic [HASH_BITS-1:0] s4_top_r, s4_bot_r;
  logic [WEIGHT_BITS-1:0] s4_v_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h[k] = HASH_BITS'(s3_p_r[k] ^ (s3_p_r[k] >> 16));
    end
  end

  // stage 5: vertical blend
  logic s5_valid_r;
  item_t s5_item_r;
  logic [HASH_BITS-1:0] s5_n_r;

  // stage 6: accumulate and hand the next octave its shifted state
  logic valid_r;
  item_t item_r;
  item_t item_nxt;
  logic [ACC_BITS-1:0] contrib;
  logic active;

  always_comb begin
    active   = {1'b0, octave_idx} < s5_item_r.oct;
    contrib  = ACC_BITS'(s5_n_r) << (OIDX_BITS'(MAX_OCTAVES - 1) - octave_idx);
    item_nxt = s5_item_r;
    item_nxt.acc = active ? s5_item_r.acc + contrib : s5_item_r.acc;
    item_nxt.rx  = {s5_item_r.rx[PER_BITS-2:0], s5_item_r.fx[FRAC_BITS-1]};
    item_nxt.ry  = {s5_item_r.ry[PER_BITS-2:0], s5_item_r.fy[FRAC_BITS-1]};
    item_nxt.fx  = {s5_item_r.fx[FRAC_BITS-2:0], 1'b0};
    item_nxt.fy  = {s5_item_r.fy[FRAC_BITS-2:0], 1'b0};
    item_nxt.per = {s5_item_r.per[PER_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      valid_r    <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_item;
      s1_m_r    <= m_nxt;
      s1_f2x_r  <= f2x_full[31:FRAC_BITS];
      s1_f2y_r  <= f2y_full[31:FRAC_BITS];
      s1_kx_r   <= K_THREE - PER_BITS'({in_item.fx, 1'b0});
      s1_ky_r   <= K_THREE - PER_BITS'({in_item.fy, 1'b0});

      s2_item_r <= s1_item_r;
      s2_t_r    <= t_nxt;
      s2_u_r    <= ux_full[FRAC_BITS+WEIGHT_BITS-1:FRAC_BITS];
      s2_v_r    <= vy_full[FRAC_BITS+WEIGHT_BITS-1:FRAC_BITS];

      s3_item_r <= s2_item_r;
      for (int k = 0; k < 4; k++) begin
        s3_p_r[k] <= s2_t_r[k] * HASH_MUL_MIX;
      end
      s3_u_r    <= s2_u_r;
      s3_v_r    <= s2_v_r;

      s4_item_r <= s3_item_r;
      s4_top_r  <= blend(h[0], h[1], s3_u_r);
      s4_bot_r  <= blend(h[2], h[3], s3_u_r);
      s4_v_r    <= s3_v_r;

      s5_item_r <= s4_item_r;
      s5_n_r    <= blend(s4_top_r, s4_bot_r, s4_v_r);

      item_r    <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  // wrapped corners must already lie inside this octave's period
  `TFVN_ASSERT_IMP(a_corner_in_period, in_valid, (in_item.rx < in_item.per) && (in_item.ry < in_item.per))

endmodule

/* rtl/tfvn_quot_cell.sv */
// One restoring-division step of the amplitude normalizer (one quotient bit).
// Depends on tfvn_pkg and the assertion macro header.
`include "tileable_fbm_value_noise_defines.svh"
module tfvn_quot_cell import tfvn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  quot_t in_item,
  output logic  out_valid,
  output quot_t out_item
);

  logic  valid_r;
  quot_t item_r;
  quot_t item_nxt;
  logic [DIV_BITS:0] part;
  logic ge;

  always_comb begin
    part = {in_item.rem, in_item.bits[OUT_BITS-1]};
    ge   = part >= {1'b0, in_item.div};
    item_nxt      = in_item;
    item_nxt.rem  = ge ? DIV_BITS'(part - {1'b0, in_item.div}) : part[DIV_BITS-1:0];
    item_nxt.bits = {in_item.bits[OUT_BITS-2:0], 1'b0};
    item_nxt.quo  = {in_item.quo[OUT_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  // partial remainder always stays below the divisor
  `TFVN_ASSERT_IMP(a_rem_below_div, valid_r, item_r.rem < item_r.div)

endmodule

/* rtl/tileable_fbm_value_noise.sv */
// Top level of the tileable fractal value noise block.
// Depends on tfvn_pkg, tfvn_wrap_cell, tfvn_octave_cell, tfvn_quot_cell and the macro header.
//
// Takes one Q12.16 (x, y) sample per cycle and returns one Q0.16 noise value per
// sample, in order: 12 wrap cells reduce the integer coordinate modulo the base
// period one bit per cycle, 8 octave cells of 6 stages each hash, blend and
// accumulate one octave apiece (the period and the wrapped coordinate are doubled
// from cell to cell, so no later octave needs a modulo), one stage scales the sum,
// and 16 division cells produce the quotient by 2^octaves - 1 one bit per cycle.
// Throughput is one sample per clock; the whole chain advances together and holds
// only while a finished result waits on out_ready.
// octave_count (index 0) is clamped to 1..8 and base_period (index 1) of 0 acts as 1;
// writes to other indexes are dropped. Write configuration only with the block idle.
`include "tileable_fbm_value_noise_defines.svh"
module tileable_fbm_value_noise import tfvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [BASE_BITS-1:0]    cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_x_coord,
  input  logic [COORD_BITS-1:0]   in_y_coord,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BITS-1:0]     out_noise_value
);

  // configuration registers
  logic [OCT_BITS-1:0]  oct_r;
  logic [BASE_BITS-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r  <= OCT_BITS'(1);
      base_r <= BASE_BITS'(4);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OCTAVE_COUNT: oct_r  <= cfg_wdata[OCT_BITS-1:0];
        REG_BASE_PERIOD:  base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: move unless the output holds an untaken result
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // entry item
  logic [OCT_BITS-1:0]  oct_eff;
  logic [BASE_BITS-1:0] base_eff;
  item_t entry;

  always_comb begin
    if (oct_r == '0) oct_eff = OCT_BITS'(1);
    else if (oct_r > OCT_BITS'(MAX_OCTAVES)) oct_eff = OCT_BITS'(MAX_OCTAVES);
    else oct_eff = oct_r;
    base_eff  = (base_r == '0) ? BASE_BITS'(1) : base_r;
    entry.fx  = in_x_coord[FRAC_BITS-1:0];
    entry.fy  = in_y_coord[FRAC_BITS-1:0];
    entry.ix  = in_x_coord[COORD_BITS-1:FRAC_BITS];
    entry.iy  = in_y_coord[COORD_BITS-1:FRAC_BITS];
    entry.rx  = '0;
    entry.ry  = '0;
    entry.per = PER_BITS'(base_eff);
    entry.oct = oct_eff;
    entry.acc = '0;
  end

  // wrap chain: integer part modulo base period, MSB first
  logic [INT_BITS:0] wrap_valid;
  item_t             wrap_item [INT_BITS+1];

  assign wrap_valid[0] = in_valid;
  assign wrap_item[0]  = entry;

  for (genvar g = 0; g < INT_BITS; g++) begin : g_wrap
    tfvn_wrap_cell u_wrap (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (wrap_valid[g]),
      .in_item   (wrap_item[g]),
      .out_valid (wrap_valid[g+1]),
      .out_item  (wrap_item[g+1])
    );
  end

  // octave chain
  logic [MAX_OCTAVES:0] oct_valid;
  item_t                oct_item [MAX_OCTAVES+1];

  assign oct_valid[0] = wrap_valid[INT_BITS];
  assign oct_item[0]  = wrap_item[INT_BITS];

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_octave
    tfvn_octave_cell u_octave (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .octave_idx (OIDX_BITS'(g)),
      .in_valid   (oct_valid[g]),
      .in_item    (oct_item[g]),
      .out_valid  (oct_valid[g+1]),
      .out_item   (oct_item[g+1])
    );
  end

  // scale: quotient = floor(((acc << oct) >> 16) / (2^oct - 1)), below 2^16
  logic [ACC_BITS+MAX_OCTAVES-1:0] scaled;
  logic [DIV_BITS:0]               div_full;
  logic                            norm_valid_r;
  quot_t                           norm_r;
  quot_t                           norm_nxt;

  always_comb begin
    scaled   = (ACC_BITS+MAX_OCTAVES)'(oct_item[MAX_OCTAVES].acc) << oct_item[MAX_OCTAVES].oct;
    div_full = ((DIV_BITS+1)'(1) << oct_item[MAX_OCTAVES].oct) - (DIV_BITS+1)'(1);
    norm_nxt.rem  = scaled[ACC_BITS+MAX_OCTAVES-1:ACC_BITS+MAX_OCTAVES-DIV_BITS];
    norm_nxt.bits = scaled[ACC_BITS+MAX_OCTAVES-DIV_BITS-1:FRAC_BITS];
    norm_nxt.quo  = '0;
    norm_nxt.div  = div_full[DIV_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_valid_r <= 1'b0;
    end else if (adv) begin
      norm_valid_r <= oct_valid[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_r <= norm_nxt;
    end
  end

  // division chain, one quotient bit per cell; last cell is the output register
  logic [OUT_BITS:0] quot_valid;
  quot_t             quot_item [OUT_BITS+1];

  assign quot_valid[0] = norm_valid_r;
  assign quot_item[0]  = norm_r;

  for (genvar g = 0; g < OUT_BITS; g++) begin : g_quot
    tfvn_quot_cell u_quot (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (quot_valid[g]),
      .in_item   (quot_item[g]),
      .out_valid (quot_valid[g+1]),
      .out_item  (quot_item[g+1])
    );
  end

  assign out_valid       = quot_valid[OUT_BITS];
  assign out_noise_value = quot_item[OUT_BITS].quo;

  `TFVN_ASSERT_NXT(a_cfg_octave_taken, cfg_wr_en && (cfg_index == REG_OCTAVE_COUNT), oct_r == $past(cfg_wdata[OCT_BITS-1:0]))
  `TFVN_ASSERT_IMP(a_stall_only_on_output, !in_ready, out_valid && !out_ready)

endmodule
